// ===== src/sacr_pkg.sv =====
package sacr_pkg;

    localparam int WAYS      = 4;
    localparam int MAX_SETS  = 128;
    localparam int ADDR_BITS = 32;
    localparam int OFF_MIN   = 4;
    localparam int OFF_MAX   = 5;

    localparam int TAG_W = ADDR_BITS - OFF_MIN;
    localparam int SET_W = $clog2(MAX_SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam int AGE_W = $clog2(WAYS);
    localparam int CFG_W = 3;
    localparam int IDX_W = 2;
    localparam int CNT_W = 32;

    localparam logic [IDX_W-1:0] CFG_REPLACE_MODE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OFFSET_BITS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_INDEX_BITS   = 2'd2;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][AGE_W-1:0] age;
    } sacr_row_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } sacr_state_t;

endpackage

// ===== src/sacr_set_mem.sv =====
module sacr_set_mem
    import sacr_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output sacr_row_t        rd_data,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  sacr_row_t        wr_data
);

    sacr_row_t mem [MAX_SETS];
    sacr_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/set_assoc_cache_replacement.sv =====
// Steps per accepted word: one set read, then one tag compare per way on a single shared
// comparator (stops at the first hit), then an update state that waits while the output
// word is stalled, writes the set back and loads the output register.
// No new word is taken before the last is done; in_stall is high while one is in work.
// Reset (rst_n, async, active low): control, counters, config (FIFO, offset 4, index 4)
// and per-set init flags clear at once; tag storage is left as is and needs no sweep.
module set_assoc_cache_replacement
    import sacr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [WAY_W-1:0]     way_used,
    output logic [CNT_W-1:0]     miss_count,
    output logic [CNT_W-1:0]     access_count
);

    sacr_state_t state_reg, state_next;

    logic             mode_reg;
    logic [CFG_W-1:0] offb_reg;
    logic [CFG_W-1:0] idxb_reg;

    logic [MAX_SETS-1:0] row_init_reg;
    logic                init_q_reg;
    logic [TAG_W-1:0]    line_reg;
    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic                hit_q_reg;
    logic                free_found_reg;
    logic [WAY_W-1:0]    free_way_reg;
    logic [AGE_W-1:0]    best_age_reg;
    logic [WAY_W-1:0]    best_way_reg;

    logic             out_valid_reg;
    logic             hit_out_reg;
    logic [WAY_W-1:0] way_out_reg;
    logic [CNT_W-1:0] misses_reg;
    logic [CNT_W-1:0] accesses_reg;

    logic             in_fire;
    logic             upd_fire;
    logic             cmp_hit;
    logic             last_way;
    logic [TAG_W-1:0] line_in;
    logic [SET_W:0]   set_mask;
    logic [SET_W-1:0] set_in;

    sacr_row_t        row_q;
    sacr_row_t        row_new;
    logic [WAYS-1:0]  valid_eff;
    logic [WAYS-1:0][AGE_W-1:0] age_eff;
    logic [WAY_W-1:0] sel_way;
    logic [AGE_W:0]   sel_rank;

    // address split
    always_comb
    begin
        if (offb_reg >= CFG_W'(OFF_MAX))
        begin
            line_in = TAG_W'(address >> OFF_MAX);
        end
        else
        begin
            line_in = TAG_W'(address >> OFF_MIN);
        end
        set_mask = (SET_W+1)'((SET_W+1)'(1) << idxb_reg) - (SET_W+1)'(1);
        set_in   = line_in[SET_W-1:0] & set_mask[SET_W-1:0];
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    sacr_set_mem u_set_mem (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (set_in),
        .rd_data (row_q),
        .wr_en   (upd_fire),
        .wr_addr (set_reg),
        .wr_data (row_new)
    );

    always_comb
    begin
        for (int y = 0; y < WAYS; y++)
        begin
            valid_eff[y] = init_q_reg && row_q.valid[y];
            age_eff[y]   = valid_eff[y] ? row_q.age[y] : AGE_W'(0);
        end
    end

    assign cmp_hit  = valid_eff[way_reg] && (row_q.tag[way_reg] == line_reg);
    assign last_way = (way_reg == WAY_W'(WAYS - 1));

    always_comb
    begin
        if (hit_q_reg)
        begin
            sel_way = way_reg;
        end
        else if (free_found_reg)
        begin
            sel_way = free_way_reg;
        end
        else
        begin
            sel_way = best_way_reg;
        end
        sel_rank = valid_eff[sel_way] ? {1'b0, age_eff[sel_way]} : (AGE_W+1)'(WAYS);
    end

    // set write-back: on a miss, or on a hit in LRU mode, make the selected way youngest
    always_comb
    begin
        row_new.tag   = row_q.tag;
        row_new.valid = valid_eff;
        row_new.age   = age_eff;
        if (!hit_q_reg || mode_reg == MODE_LRU)
        begin
            for (int y = 0; y < WAYS; y++)
            begin
                if (WAY_W'(y) == sel_way)
                begin
                    row_new.age[y]   = AGE_W'(0);
                    row_new.valid[y] = 1'b1;
                    if (!hit_q_reg)
                    begin
                        row_new.tag[y] = line_reg;
                    end
                end
                else if (valid_eff[y] && ({1'b0, age_eff[y]} < sel_rank))
                begin
                    row_new.age[y] = age_eff[y] + AGE_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        upd_fire   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (cmp_hit || last_way)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    upd_fire   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FIFO;
            offb_reg <= CFG_W'(4);
            idxb_reg <= CFG_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPLACE_MODE: mode_reg <= cfg_data[0];
                CFG_OFFSET_BITS:  offb_reg <= cfg_data;
                CFG_INDEX_BITS:   idxb_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // compare loop, one way per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_reg        <= '0;
            hit_q_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            init_q_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            way_reg        <= '0;
            hit_q_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_age_reg   <= '0;
            best_way_reg   <= '0;
            init_q_reg     <= row_init_reg[set_in];
            line_reg       <= line_in;
            set_reg        <= set_in;
        end
        else if (state_reg == ST_CMP)
        begin
            if (!valid_eff[way_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_way_reg   <= way_reg;
            end
            if (age_eff[way_reg] > best_age_reg)
            begin
                best_age_reg <= age_eff[way_reg];
                best_way_reg <= way_reg;
            end
            if (cmp_hit)
            begin
                hit_q_reg <= 1'b1;
            end
            else if (!last_way)
            begin
                way_reg <= way_reg + WAY_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg  <= '0;
            out_valid_reg <= 1'b0;
            misses_reg    <= '0;
            accesses_reg  <= '0;
        end
        else if (upd_fire)
        begin
            row_init_reg[set_reg] <= 1'b1;
            out_valid_reg         <= 1'b1;
            hit_out_reg           <= hit_q_reg;
            way_out_reg           <= sel_way;
            if (accesses_reg != '1)
            begin
                accesses_reg <= accesses_reg + CNT_W'(1);
            end
            if (!hit_q_reg && misses_reg != '1)
            begin
                misses_reg <= misses_reg + CNT_W'(1);
            end
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_out_reg;
    assign way_used     = way_out_reg;
    assign miss_count   = misses_reg;
    assign access_count = accesses_reg;

`ifndef SYNTH
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        accesses_reg >= misses_reg)
        else $error("miss count exceeds access count");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && !hit_q_reg && misses_reg != '1)
        |=> (misses_reg == $past(misses_reg) + CNT_W'(1)))
        else $error("miss not counted");

    a_free_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && !hit_q_reg && free_found_reg) |-> !valid_eff[sel_way])
        else $error("fill chose a valid way while a free way exists");

    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("update did not load the output word");
`endif

endmodule

// ===== tb/tb.sv =====
module tb
    import sacr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 500000;
    localparam int PHASES = 6;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam bit MODE_TAB [PHASES] = '{MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU,
                                         MODE_FIFO, MODE_LRU};
    localparam bit [2:0] OFF_TAB [PHASES] = '{3'd4, 3'd0, 3'd7, 3'd3, 3'd6, 3'd4};
    localparam bit [2:0] IDX_TAB [PHASES] = '{3'd7, 3'd0, 3'd5, 3'd6, 3'd1, 3'd2};
    localparam int COUNT_TAB [PHASES] = '{150, 120, 150, 150, 150, 150};

    localparam logic [31:0] FIFO_SEQ [12] = '{32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF,
        32'hFFFF_FFF0, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 32'h0000_0400,
        32'h0000_0000, 32'h0000_0200, 32'h0000_0500, 32'h8000_0008};
    localparam logic [31:0] LRU_SEQ [10] = '{32'h0000_1000, 32'h0000_1100, 32'h0000_1200,
        32'h0000_1300, 32'h0000_1000, 32'h0000_1400, 32'h0000_1200, 32'h0000_1500,
        32'h0000_1000, 32'h7FFF_FFE0};

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] accesses;
    } lookup_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ADDR_BITS-1:0] address = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 hit;
    logic [WAY_W-1:0]     way_used;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     access_count;

    set_assoc_cache_replacement dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .way_used     (way_used),
        .miss_count   (miss_count),
        .access_count (access_count)
    );

    // directory mirror
    bit [TAG_W-1:0]     line_tag [MAX_SETS*WAYS];
    bit                 line_valid [MAX_SETS*WAYS];
    bit [AGE_W-1:0]     line_age [MAX_SETS*WAYS];
    bit [CNT_W-1:0]     miss_total;
    bit [CNT_W-1:0]     access_total;
    bit                 mode_reg = MODE_FIFO;
    bit [2:0]           offset_reg = 3'd4;
    bit [2:0]           index_reg = 3'd4;

    logic [ADDR_BITS-1:0] addr_q[$];
    lookup_t              lookups_due[$];
    lookup_t              want;
    int                   errors;
    int                   cycles;
    int                   send_gap;
    int                   stall_left;
    bit                   idle_on;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int eff_offset();
        return (offset_reg < 4) ? 4 : ((offset_reg > 5) ? 5 : int'(offset_reg));
    endfunction

    function automatic void make_youngest(int base, int w);
        int r;
        r = line_valid[base + w] ? int'(line_age[base + w]) : WAYS;
        for (int y = 0; y < WAYS; y++)
        begin
            if (y != w && line_valid[base + y] && line_age[base + y] < r)
                line_age[base + y] = line_age[base + y] + 1'b1;
        end
        line_age[base + w] = '0;
        line_valid[base + w] = 1'b1;
    endfunction

    function automatic lookup_t cache_lookup(logic [ADDR_BITS-1:0] a);
        logic [TAG_W-1:0] line;
        int               base;
        int               way;
        int               oldest;
        bit               found;
        lookup_t          res;
        line = TAG_W'(a >> eff_offset());
        base = (int'(line & ((TAG_W'(1) << index_reg) - 1'b1)) % MAX_SETS) * WAYS;
        way = 0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && line_valid[base + w] && line_tag[base + w] == line)
            begin
                found = 1'b1;
                way = w;
            end
        end
        res.hit = found;
        if (found)
        begin
            if (mode_reg == MODE_LRU)
                make_youngest(base, way);
        end
        else
        begin
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (!line_valid[base + w])
                begin
                    way = w;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                oldest = 0;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (line_age[base + w] > oldest)
                    begin
                        oldest = line_age[base + w];
                        way = w;
                    end
                end
            end
            make_youngest(base, way);
            line_tag[base + way] = line;
            if (miss_total != '1)
                miss_total++;
        end
        if (access_total != '1)
            access_total++;
        res.way = WAY_W'(way);
        res.misses = miss_total;
        res.accesses = access_total;
        return res;
    endfunction

    // mostly reuse a handful of lines per set so hits and evictions happen
    function automatic logic [ADDR_BITS-1:0] pick_address(logic [31:0] pool_base);
        int          ob;
        int          s;
        logic [31:0] line;
        if ($urandom_range(0, 9) < 3)
            return $urandom();
        ob = eff_offset();
        s = $urandom_range(0, 3) & ((1 << index_reg) - 1);
        line = ((pool_base + $urandom_range(0, 5)) << index_reg) | s;
        return (line << ob) | ($urandom() & ((1 << ob) - 1));
    endfunction

    task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_REPLACE_MODE: mode_reg = data[0];
            CFG_OFFSET_BITS:  offset_reg = data;
            CFG_INDEX_BITS:   index_reg = data;
            default:          ;
        endcase
    endtask

    task automatic set_config(bit mode, bit [2:0] off, bit [2:0] idx);
        write_reg(CFG_REPLACE_MODE, {2'($urandom_range(0, 3)), mode});
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_INDEX_BITS, idx);
        write_reg(CFG_UNUSED, 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_drain();
        while (addr_q.size() != 0 || in_valid || lookups_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_random(int n);
        logic [31:0] pool_base;
        pool_base = $urandom();
        for (int i = 0; i < n; i++)
            addr_q.push_back(pick_address(pool_base));
    endtask

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            lookups_due.push_back(cache_lookup(address));
        if (!rst_n || (in_valid && in_stall))
        begin
            // hold
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap--;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            send_gap = $urandom_range(0, 17);
        end
        else if (addr_q.size() != 0)
        begin
            in_valid <= 1'b1;
            address <= addr_q.pop_front();
        end
        else
            in_valid <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (lookups_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got hit=%b way=%0d miss=%h acc=%h",
                         $time, hit, way_used, miss_count, access_count);
            end
            else
            begin
                want = lookups_due.pop_front();
                check_field("hit", 32'(want.hit), 32'(hit));
                check_field("way_used", 32'(want.way), 32'(way_used));
                check_field("miss_count", want.misses, miss_count);
                check_field("access_count", want.accesses, access_count);
            end
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 17);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        idle_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (FIFO_SEQ[i])
            addr_q.push_back(FIFO_SEQ[i]);
        wait_drain();

        set_config(MODE_LRU, 3'd5, 3'd3);
        foreach (LRU_SEQ[i])
            addr_q.push_back(LRU_SEQ[i]);
        push_random(150);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drain();
            set_config(MODE_TAB[p], OFF_TAB[p], IDX_TAB[p]);
            idle_on = (p != PHASES - 1);
            push_random(COUNT_TAB[p]);
        end
        wait_drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
